// File: rtl/ptm_pkg.sv
// ----------------------------------------------------------------------------
// ptm_pkg: shared types and constants of the page table block
// Item layouts, command and job codes and the field widths used by the front,
// the job queue and the back end.
// ----------------------------------------------------------------------------
package ptm_pkg;

  localparam int VPAGE_BITS_DEF = 16;
  localparam int MAX_RUN_DEF    = 64;

  localparam int PAGE_SHIFT = 12;
  localparam int VADDR_W    = 28;
  localparam int PADDR_W    = 32;
  localparam int FRAME_W    = 20;
  localparam int VPN_W      = VADDR_W - PAGE_SHIFT;
  localparam int COUNT_W    = 7;
  localparam int ENTRY_W    = FRAME_W + 1;

  typedef enum logic [1:0] {
    CMD_MAP   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_XLATE = 2'd2,
    CMD_CHECK = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    K_MAP,
    K_CLEAR,
    K_XLATE,
    K_CHECK,
    K_EMPTY
  } kind_t;

  typedef struct packed {
    logic [1:0]         command;
    logic [VADDR_W-1:0] virt_addr;
    logic [PADDR_W-1:0] phys_addr;
    logic [COUNT_W-1:0] page_count;
    logic               mass_flush;
  } in_item_t;

  typedef struct packed {
    logic [PADDR_W-1:0] result_addr;
    logic               present;
    logic               invalidate;
    logic [VADDR_W-1:0] invalidate_addr;
    logic               reload_directory;
    logic               last;
  } out_item_t;

  typedef struct packed {
    kind_t                 kind;
    logic [VPN_W-1:0]      vpn;
    logic [PAGE_SHIFT-1:0] offset;
    logic [FRAME_W-1:0]    frame;
    logic [COUNT_W-1:0]    count;
    logic                  flush;
  } job_t;

  typedef struct packed {
    logic clearing;
    logic run_busy;
  } back_stat_t;

endpackage

// File: rtl/page_table_map_translate.sv
// ----------------------------------------------------------------------------
// page_table_map_translate: flat page table with map, clear and lookup
// Results pass the issue stage, response stage and output register in turn.
// Throughput: one translate or check per cycle outside runs and the clearing
// pass; a map or clear run gives one result per page on consecutive cycles,
// set by the single table write port. Reset: a clearing pass, busy high,
// zeroes 2^VPAGE_BITS entries. Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module page_table_map_translate import ptm_pkg::*; #(
  parameter int VPAGE_BITS = VPAGE_BITS_DEF,
  parameter int MAX_RUN    = MAX_RUN_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  in_item_t  in_data,
  output logic      busy,
  output logic      out_valid,
  output out_item_t out_data
);

  logic       push;
  job_t       push_job;
  logic       pop;
  logic       q_valid;
  job_t       q_job;
  logic       q_full;
  back_stat_t stat;

  ptm_front #(
    .MAX_RUN(MAX_RUN)
  ) u_front (
    .start  (start),
    .in_data(in_data),
    .q_full (q_full),
    .bstat  (stat),
    .busy   (busy),
    .push   (push),
    .job    (push_job)
  );

  ptm_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_job(push_job),
    .pop     (pop),
    .q_valid (q_valid),
    .q_job   (q_job),
    .q_full  (q_full)
  );

  ptm_back #(
    .VPAGE_BITS(VPAGE_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_job    (q_job),
    .pop      (pop),
    .out_valid(out_valid),
    .out_data (out_data),
    .stat     (stat)
  );

`ifndef SYNTH
  a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
    stat.clearing |-> busy)
    else $error("item could be accepted during the clearing pass");

  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    stat.clearing |-> (!stat.run_busy && !out_valid))
    else $error("job activity during the clearing pass");

  a_run_gapless: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.last) |=> out_valid)
    else $error("gap inside a run of results");

  a_flag_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.invalidate && out_data.reload_directory))
    else $error("invalidate and reload set on the same result");
`endif

endmodule

// File: rtl/ptm_ram.sv
// ----------------------------------------------------------------------------
// ptm_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ptm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/ptm_front.sv
// ----------------------------------------------------------------------------
// ptm_front: command intake and classification
// Accepts items, saturates run lengths and sorts each item into a job kind
// for the back end.
// ----------------------------------------------------------------------------
module ptm_front import ptm_pkg::*; #(
  parameter int MAX_RUN = MAX_RUN_DEF
) (
  input  logic       start,
  input  in_item_t   in_data,
  input  logic       q_full,
  input  back_stat_t bstat,
  output logic       busy,
  output logic       push,
  output job_t       job
);

  logic [COUNT_W-1:0] run_len;

  assign busy = q_full | bstat.clearing;
  assign push = start & ~busy;

  always_comb begin
    if (in_data.page_count > COUNT_W'(MAX_RUN)) begin
      run_len = COUNT_W'(MAX_RUN);
    end else begin
      run_len = in_data.page_count;
    end

    job.vpn    = in_data.virt_addr[VADDR_W-1:PAGE_SHIFT];
    job.offset = in_data.virt_addr[PAGE_SHIFT-1:0];
    job.frame  = in_data.phys_addr[PADDR_W-1:PAGE_SHIFT];
    job.count  = run_len;
    job.flush  = in_data.mass_flush;

    case (in_data.command)
      CMD_MAP:   job.kind = (run_len == '0) ? K_EMPTY : K_MAP;
      CMD_CLEAR: job.kind = (run_len == '0) ? K_EMPTY : K_CLEAR;
      CMD_XLATE: job.kind = K_XLATE;
      CMD_CHECK: job.kind = K_CHECK;
      default:   job.kind = K_CHECK;
    endcase
  end

endmodule

// File: rtl/ptm_queue.sv
// ----------------------------------------------------------------------------
// ptm_queue: two-entry job queue
// Decouples the intake from the back end so that each may stall on its own.
// ----------------------------------------------------------------------------
module ptm_queue import ptm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic q_valid,
  output job_t q_job,
  output logic q_full
);

  job_t       slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;

  assign q_valid = (cnt_r != 2'd0);
  assign q_full  = (cnt_r == 2'd2);
  assign q_job   = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        slot_r[wr_ptr_r] <= push_job;
        wr_ptr_r         <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule

// File: rtl/ptm_back.sv
// ----------------------------------------------------------------------------
// ptm_back: page table execution engine
// Clears the table after reset, then walks each job through an issue stage
// and a response stage around the table RAM, one page per cycle.
// ----------------------------------------------------------------------------
module ptm_back import ptm_pkg::*; #(
  parameter int VPAGE_BITS = VPAGE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  job_t       q_job,
  output logic       pop,
  output logic       out_valid,
  output out_item_t  out_data,
  output back_stat_t stat
);

  localparam int IDX_W = VPAGE_BITS;
  localparam int DEPTH = 1 << VPAGE_BITS;

  logic                  clr_r;
  logic [IDX_W-1:0]      clr_cnt_r;

  logic                  a_act_r;
  kind_t                 a_kind_r;
  logic [IDX_W-1:0]      a_idx_r;
  logic [FRAME_W-1:0]    a_frame_r;
  logic [COUNT_W-1:0]    a_rem_r;
  logic                  a_flush_r;
  logic [PAGE_SHIFT-1:0] a_off_r;

  logic                  b_vld_r;
  kind_t                 b_kind_r;
  logic [IDX_W-1:0]      b_idx_r;
  logic [FRAME_W-1:0]    b_frame_r;
  logic                  b_flush_r;
  logic                  b_last_r;
  logic [PAGE_SHIFT-1:0] b_off_r;

  logic                  fwd_r;
  logic [ENTRY_W-1:0]    fwd_data_r;

  logic                  out_valid_r;
  out_item_t             out_r;
  out_item_t             out_nxt;

  logic                  a_is_run;
  logic                  a_last;
  logic                  load;
  logic                  rd_en;
  logic [IDX_W+VPN_W-1:0] vpn_ext;
  logic [IDX_W-1:0]      idx_base;
  logic [ENTRY_W-1:0]    rdata;
  logic [ENTRY_W-1:0]    entry;
  logic                  b_is_run;
  logic                  we;
  logic [IDX_W-1:0]      waddr;
  logic [ENTRY_W-1:0]    wdata;
  logic [IDX_W+VADDR_W-1:0] inv_ext;

  assign a_is_run = (a_kind_r == K_MAP) || (a_kind_r == K_CLEAR);
  assign a_last   = !a_is_run || (a_rem_r == COUNT_W'(1));
  assign load     = !clr_r && q_valid && (!a_act_r || a_last);
  assign pop      = load;
  assign rd_en    = a_act_r && (a_kind_r != K_EMPTY);

  assign vpn_ext  = {{IDX_W{1'b0}}, q_job.vpn};
  assign idx_base = vpn_ext[IDX_W-1:0];

  assign entry    = fwd_r ? fwd_data_r : rdata;
  assign b_is_run = (b_kind_r == K_MAP) || (b_kind_r == K_CLEAR);
  assign we       = clr_r || (b_vld_r && b_is_run);
  assign waddr    = clr_r ? clr_cnt_r : b_idx_r;
  assign wdata    = (!clr_r && b_kind_r == K_MAP) ? {b_frame_r, 1'b1} : '0;
  assign inv_ext  = {{(VADDR_W - PAGE_SHIFT){1'b0}}, b_idx_r, {PAGE_SHIFT{1'b0}}};

  ptm_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (rd_en),
    .raddr(a_idx_r),
    .rdata(rdata)
  );

  always_comb begin
    out_nxt = '0;
    case (b_kind_r)
      K_MAP, K_CLEAR: begin
        out_nxt.invalidate       = entry[0] & ~b_flush_r;
        out_nxt.invalidate_addr  = inv_ext[VADDR_W-1:0];
        out_nxt.reload_directory = b_last_r & b_flush_r;
        out_nxt.last             = b_last_r;
      end
      K_XLATE: begin
        out_nxt.result_addr = {entry[ENTRY_W-1:1], b_off_r};
        out_nxt.present     = entry[0];
        out_nxt.last        = 1'b1;
      end
      K_CHECK: begin
        out_nxt.present = entry[0];
        out_nxt.last    = 1'b1;
      end
      K_EMPTY: begin
        out_nxt.reload_directory = b_flush_r;
        out_nxt.last             = 1'b1;
      end
      default: begin
        out_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= 1'b1;
      clr_cnt_r   <= '0;
      a_act_r     <= 1'b0;
      b_vld_r     <= 1'b0;
      fwd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (clr_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == '1) begin
          clr_r <= 1'b0;
        end
      end

      if (load) begin
        a_act_r   <= 1'b1;
        a_kind_r  <= q_job.kind;
        a_idx_r   <= idx_base;
        a_frame_r <= q_job.frame;
        a_rem_r   <= q_job.count;
        a_flush_r <= q_job.flush;
        a_off_r   <= q_job.offset;
      end else if (a_act_r && a_last) begin
        a_act_r <= 1'b0;
      end else if (a_act_r) begin
        a_rem_r   <= a_rem_r - 1'b1;
        a_idx_r   <= a_idx_r + 1'b1;
        a_frame_r <= a_frame_r + 1'b1;
      end

      b_vld_r   <= a_act_r;
      b_kind_r  <= a_kind_r;
      b_idx_r   <= a_idx_r;
      b_frame_r <= a_frame_r;
      b_flush_r <= a_flush_r;
      b_last_r  <= a_last;
      b_off_r   <= a_off_r;

      // A write landing in the same cycle as a read of that entry is forwarded.
      fwd_r      <= rd_en && we && (waddr == a_idx_r);
      fwd_data_r <= wdata;

      out_valid_r <= b_vld_r;
      out_r       <= out_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_data      = out_r;
  assign stat.clearing = clr_r;
  assign stat.run_busy = a_act_r;

endmodule
